// ===== design/resistive_touch_event_mapper_macros.svh =====
// assertion macros used by the checker file
`ifndef RESISTIVE_TOUCH_EVENT_MAPPER_MACROS_SVH
`define RESISTIVE_TOUCH_EVENT_MAPPER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define RTEM_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rtem check failed");

// next-cycle implication, disabled while reset is low
`define RTEM_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rtem check failed");

`endif

// ===== design/rtem_pkg.sv =====
// types, constants and codes of the resistive touch event mapper
`default_nettype none

package rtem_pkg;

    // field widths
    localparam int SAMPLE_W        = 12;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 12;
    localparam int PROD_W          = 2 * SAMPLE_W;
    localparam int IN_TDATA_W      = 40;
    localparam int IN_TUSER_W      = 2;
    localparam int OUT_TDATA_W     = 56;
    localparam int OUT_TUSER_W     = 1;
    localparam int ADC_BITS_DEFAULT = 12;

    // serial divider: one quotient bit per step
    localparam int DIV_STEPS   = PROD_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_RAW_LOW       = 3'd0,
        CFG_X_RAW_HIGH      = 3'd1,
        CFG_Y_RAW_LOW       = 3'd2,
        CFG_Y_RAW_HIGH      = 3'd3,
        CFG_SCREEN_WIDTH    = 3'd4,
        CFG_SCREEN_HEIGHT   = 3'd5,
        CFG_INVERT_AXES     = 3'd6,
        CFG_PRESS_THRESHOLD = 3'd7
    } cfg_index_t;

    // reported touch state codes
    typedef enum logic [1:0] {
        TS_PRESSED  = 2'd0,
        TS_MOVED    = 2'd1,
        TS_RELEASED = 2'd2
    } touch_state_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } state_t;

    // configuration register set
    typedef struct packed {
        logic [SAMPLE_W-1:0] x_raw_low;
        logic [SAMPLE_W-1:0] x_raw_high;
        logic [SAMPLE_W-1:0] y_raw_low;
        logic [SAMPLE_W-1:0] y_raw_high;
        logic [SAMPLE_W-1:0] screen_width;
        logic [SAMPLE_W-1:0] screen_height;
        logic [1:0]          invert_axes;
        logic [SAMPLE_W-1:0] press_threshold;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic                status;
        logic                point_count;
        touch_state_t        touch_state;
        logic [SAMPLE_W-1:0] x_pos;
        logic [SAMPLE_W-1:0] y_pos;
        logic [SAMPLE_W-1:0] raw_x_echo;
        logic [SAMPLE_W-1:0] raw_y_echo;
    } result_t;

    // divider request from the sequencer
    typedef struct packed {
        logic                start;
        logic [PROD_W-1:0]   dividend;
        logic [SAMPLE_W-1:0] divisor;
    } div_req_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } div_sts_t;

endpackage

`default_nettype wire

// ===== design/rtem_div.sv =====
// shared serial restoring divider, one quotient bit per cycle
`default_nettype none

module rtem_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire rtem_pkg::div_req_t div_req,
    output rtem_pkg::div_sts_t     div_sts
);

    localparam logic [rtem_pkg::DIV_CNT_W-1:0] StepsInit =
        rtem_pkg::DIV_CNT_W'(rtem_pkg::DIV_STEPS);
    localparam logic [rtem_pkg::DIV_CNT_W-1:0] LastStep =
        rtem_pkg::DIV_CNT_W'(1);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [rtem_pkg::DIV_CNT_W-1:0]    count_reg, count_next;
    logic [rtem_pkg::SAMPLE_W-1:0]     rem_reg, rem_next;
    logic [rtem_pkg::PROD_W-1:0]       quo_reg, quo_next;
    logic [rtem_pkg::SAMPLE_W-1:0]     divisor_reg, divisor_next;
    logic [rtem_pkg::SAMPLE_W:0]       trial;
    logic [rtem_pkg::SAMPLE_W:0]       trial_diff;
    logic                              fits;

    // one trial subtraction per cycle
    assign trial      = {rem_reg, quo_reg[rtem_pkg::PROD_W-1]};
    assign trial_diff = trial - {1'b0, divisor_reg};
    assign fits       = (trial >= {1'b0, divisor_reg});

    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (div_req.start) begin
            busy_next    = 1'b1;
            count_next   = StepsInit;
            rem_next     = '0;
            quo_next     = div_req.dividend;
            divisor_next = div_req.divisor;
        end else if (busy_reg) begin
            rem_next   = fits ? trial_diff[rtem_pkg::SAMPLE_W-1:0]
                              : trial[rtem_pkg::SAMPLE_W-1:0];
            quo_next   = {quo_reg[rtem_pkg::PROD_W-2:0], fits};
            count_next = count_reg - LastStep;
            if (count_reg == LastStep) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign div_sts.done     = done_reg;
    assign div_sts.quotient = quo_reg;

endmodule

`default_nettype wire

// ===== design/rtem_ctrl.sv =====
// poll sequencer: touch decision, per-axis scaling through the shared divider
`default_nettype none

module rtem_ctrl #(
    parameter int ADC_BITS = rtem_pkg::ADC_BITS_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire rtem_pkg::cfg_t                cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [rtem_pkg::SAMPLE_W-1:0] in_contact,
    input  wire logic                          in_contact_ok,
    input  wire logic [rtem_pkg::SAMPLE_W-1:0] in_x,
    input  wire logic [rtem_pkg::SAMPLE_W-1:0] in_y,
    input  wire logic                          in_position_ok,
    input  wire logic                          out_free,
    output logic                               res_valid,
    output rtem_pkg::result_t                  res,
    output rtem_pkg::div_req_t                 div_req,
    input  wire rtem_pkg::div_sts_t            div_sts
);

    localparam int MaskBits = (ADC_BITS < rtem_pkg::SAMPLE_W) ? ADC_BITS : rtem_pkg::SAMPLE_W;
    localparam logic [rtem_pkg::SAMPLE_W-1:0] AdcMask =
        rtem_pkg::SAMPLE_W'((64'd1 << MaskBits) - 64'd1);
    localparam logic [rtem_pkg::SAMPLE_W-1:0] One = rtem_pkg::SAMPLE_W'(1);

    rtem_pkg::state_t                  state_reg, state_next;
    rtem_pkg::result_t                 res_reg, res_next;
    logic                              axis_reg, axis_next;
    logic                              was_touched_reg, was_touched_next;
    logic                              neg_reg, neg_next;
    logic                              span_zero_reg, span_zero_next;
    logic [rtem_pkg::SAMPLE_W-1:0]     diff_mag_reg, diff_mag_next;
    logic [rtem_pkg::SAMPLE_W-1:0]     span_mag_reg, span_mag_next;

    logic [rtem_pkg::SAMPLE_W-1:0]     contact_m, x_m, y_m;
    logic                              touched;
    logic [rtem_pkg::SAMPLE_W-1:0]     ax_raw, ax_lo, ax_hi, ax_size;
    logic                              ax_mirror;
    logic [rtem_pkg::SAMPLE_W:0]       diff, span;
    logic [rtem_pkg::PROD_W-1:0]       product;
    logic [rtem_pkg::PROD_W-1:0]       quot;
    logic [rtem_pkg::SAMPLE_W-1:0]     clamped, coord;

    // sample masking and touch decision
    assign contact_m = in_contact & AdcMask;
    assign x_m       = in_x & AdcMask;
    assign y_m       = in_y & AdcMask;
    assign touched   = in_contact_ok && (contact_m < cfg.press_threshold);

    // axis operand selection
    always_comb begin
        if (axis_reg) begin
            ax_raw    = res_reg.raw_y_echo;
            ax_lo     = cfg.y_raw_low;
            ax_hi     = cfg.y_raw_high;
            ax_size   = cfg.screen_height;
            ax_mirror = cfg.invert_axes[1];
        end else begin
            ax_raw    = res_reg.raw_x_echo;
            ax_lo     = cfg.x_raw_low;
            ax_hi     = cfg.x_raw_high;
            ax_size   = cfg.screen_width;
            ax_mirror = cfg.invert_axes[0];
        end
    end

    // signed offsets as sign and magnitude
    assign diff = {1'b0, ax_raw} - {1'b0, ax_lo};
    assign span = {1'b0, ax_hi} - {1'b0, ax_lo};

    // numerator magnitude, registered in the divider
    assign product = diff_mag_reg * ax_size;

    // clamp to the screen and mirror
    always_comb begin
        quot = span_zero_reg ? '0 : div_sts.quotient;
        if (neg_reg) begin
            clamped = '0;
        end else if (quot >= {{rtem_pkg::SAMPLE_W{1'b0}}, ax_size}) begin
            clamped = ax_size - One;
        end else begin
            clamped = quot[rtem_pkg::SAMPLE_W-1:0];
        end
        if (ax_size == '0) begin
            coord = '0;
        end else if (ax_mirror) begin
            coord = ax_size - One - clamped;
        end else begin
            coord = clamped;
        end
    end

    // next state and outputs
    always_comb begin
        state_next       = state_reg;
        res_next         = res_reg;
        axis_next        = axis_reg;
        was_touched_next = was_touched_reg;
        neg_next         = neg_reg;
        span_zero_next   = span_zero_reg;
        diff_mag_next    = diff_mag_reg;
        span_mag_next    = span_mag_reg;
        in_ready         = 1'b0;
        res_valid        = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = product;
        div_req.divisor  = span_mag_reg;
        unique case (state_reg)
            rtem_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    res_next  = '0;
                    axis_next = 1'b0;
                    if (!touched) begin
                        // release reported only after a pressed poll
                        if (was_touched_reg) begin
                            res_next.point_count = 1'b1;
                            res_next.touch_state = rtem_pkg::TS_RELEASED;
                        end
                        was_touched_next = 1'b0;
                        state_next       = rtem_pkg::ST_DONE;
                    end else if (!in_position_ok) begin
                        // conversion failure keeps the touch state
                        res_next.status = 1'b1;
                        state_next      = rtem_pkg::ST_DONE;
                    end else begin
                        res_next.point_count = 1'b1;
                        res_next.touch_state = was_touched_reg ? rtem_pkg::TS_MOVED
                                                               : rtem_pkg::TS_PRESSED;
                        res_next.raw_x_echo  = x_m;
                        res_next.raw_y_echo  = y_m;
                        was_touched_next     = 1'b1;
                        state_next           = rtem_pkg::ST_PREP;
                    end
                end
            end
            rtem_pkg::ST_PREP: begin
                diff_mag_next  = diff[rtem_pkg::SAMPLE_W]
                    ? rtem_pkg::SAMPLE_W'(-diff) : diff[rtem_pkg::SAMPLE_W-1:0];
                span_mag_next  = span[rtem_pkg::SAMPLE_W]
                    ? rtem_pkg::SAMPLE_W'(-span) : span[rtem_pkg::SAMPLE_W-1:0];
                neg_next       = diff[rtem_pkg::SAMPLE_W] ^ span[rtem_pkg::SAMPLE_W];
                span_zero_next = (span == '0);
                state_next     = rtem_pkg::ST_MUL;
            end
            rtem_pkg::ST_MUL: begin
                if (span_zero_reg) begin
                    state_next = rtem_pkg::ST_FIN;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = rtem_pkg::ST_DIV;
                end
            end
            rtem_pkg::ST_DIV: begin
                if (div_sts.done) begin
                    state_next = rtem_pkg::ST_FIN;
                end
            end
            rtem_pkg::ST_FIN: begin
                if (axis_reg) begin
                    res_next.y_pos = coord;
                    state_next     = rtem_pkg::ST_DONE;
                end else begin
                    res_next.x_pos = coord;
                    axis_next      = 1'b1;
                    state_next     = rtem_pkg::ST_PREP;
                end
            end
            rtem_pkg::ST_DONE: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = rtem_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rtem_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= rtem_pkg::ST_IDLE;
            was_touched_reg <= 1'b0;
            axis_reg        <= 1'b0;
        end else begin
            state_reg       <= state_next;
            was_touched_reg <= was_touched_next;
            axis_reg        <= axis_next;
        end
    end

    // working payload
    always_ff @(posedge aclk) begin
        res_reg       <= res_next;
        neg_reg       <= neg_next;
        span_zero_reg <= span_zero_next;
        diff_mag_reg  <= diff_mag_next;
        span_mag_reg  <= span_mag_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ===== design/resistive_touch_event_mapper.sv =====
// Resistive touch event mapper: turns panel polls into pressed, moved or released points.
// Input channel s_*: one request per poll; result channel m_*: exactly one result per poll.
// Configuration is written through cfg_we / cfg_addr / cfg_wdata; the user must write it
// only while no poll is pending, as the block itself does not enforce this. A poll with no
// touch or a failed position conversion goes straight to the DONE state. A touched poll
// scales X, then Y, through one shared multiplier and one serial divider: per axis an
// operand prep step, a multiply step, a serial division of 24 steps with one quotient bit
// each and a wait for its done flag (both skipped when the axis span is zero), and a clamp
// step. From the DONE state every result passes to the output register. s_tready is high
// only while no poll is in work; it may be high while an earlier result still sits in the
// output register. If the receiver stalls, the finished poll waits in the sequencer and no
// new request is taken until the output register frees. Reset clears the press history,
// the output valid and restores the calibration registers to their defaults.
`default_nettype none

module resistive_touch_event_mapper #(
    parameter int ADC_BITS = rtem_pkg::ADC_BITS_DEFAULT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration write port
    input  wire logic                               cfg_we,
    input  wire logic [rtem_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [rtem_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // poll requests
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // contact_sample[11:0], sample_x[23:12], sample_y[35:24], zero pad[39:36]
    input  wire logic [rtem_pkg::IN_TDATA_W-1:0]    s_tdata,
    // contact_ok[0], position_ok[1]
    input  wire logic [rtem_pkg::IN_TUSER_W-1:0]    s_tuser,
    // result requests
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // point_count[0], touch_state[2:1], x_pos[14:3], y_pos[26:15],
    // raw_x_echo[38:27], raw_y_echo[50:39], zero pad[55:51]
    output logic [rtem_pkg::OUT_TDATA_W-1:0]        m_tdata,
    // status[0]
    output logic [rtem_pkg::OUT_TUSER_W-1:0]        m_tuser
);

    localparam int ResW = 3 + 4 * rtem_pkg::SAMPLE_W;

    rtem_pkg::cfg_t     cfg_reg, cfg_next;
    rtem_pkg::result_t  out_res_reg, out_res_next;
    logic               out_valid_reg, out_valid_next;
    rtem_pkg::result_t  res;
    logic               res_valid;
    logic               out_free;
    rtem_pkg::div_req_t div_req;
    rtem_pkg::div_sts_t div_sts;

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (rtem_pkg::cfg_index_t'(cfg_addr))
                rtem_pkg::CFG_X_RAW_LOW:       cfg_next.x_raw_low       = cfg_wdata;
                rtem_pkg::CFG_X_RAW_HIGH:      cfg_next.x_raw_high      = cfg_wdata;
                rtem_pkg::CFG_Y_RAW_LOW:       cfg_next.y_raw_low       = cfg_wdata;
                rtem_pkg::CFG_Y_RAW_HIGH:      cfg_next.y_raw_high      = cfg_wdata;
                rtem_pkg::CFG_SCREEN_WIDTH:    cfg_next.screen_width    = cfg_wdata;
                rtem_pkg::CFG_SCREEN_HEIGHT:   cfg_next.screen_height   = cfg_wdata;
                rtem_pkg::CFG_INVERT_AXES:     cfg_next.invert_axes     = cfg_wdata[1:0];
                rtem_pkg::CFG_PRESS_THRESHOLD: cfg_next.press_threshold = cfg_wdata;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_raw_low       <= 12'd0;
            cfg_reg.x_raw_high      <= 12'd4095;
            cfg_reg.y_raw_low       <= 12'd0;
            cfg_reg.y_raw_high      <= 12'd4095;
            cfg_reg.screen_width    <= 12'd320;
            cfg_reg.screen_height   <= 12'd240;
            cfg_reg.invert_axes     <= 2'd0;
            cfg_reg.press_threshold <= 12'd2048;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // output register
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid) begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg <= out_res_next;
    end

    // result packing
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {
        (rtem_pkg::OUT_TDATA_W - ResW)'(0),
        out_res_reg.raw_y_echo,
        out_res_reg.raw_x_echo,
        out_res_reg.y_pos,
        out_res_reg.x_pos,
        out_res_reg.touch_state,
        out_res_reg.point_count
    };

    // poll sequencer
    rtem_ctrl #(
        .ADC_BITS(ADC_BITS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_contact    (s_tdata[11:0]),
        .in_contact_ok (s_tuser[0]),
        .in_x          (s_tdata[23:12]),
        .in_y          (s_tdata[35:24]),
        .in_position_ok(s_tuser[1]),
        .out_free      (out_free),
        .res_valid     (res_valid),
        .res           (res),
        .div_req       (div_req),
        .div_sts       (div_sts)
    );

    // shared divider
    rtem_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .div_req(div_req),
        .div_sts(div_sts)
    );

endmodule

`default_nettype wire

// ===== design/rtem_checker.sv =====
// port-level checks of the touch event mapper and their binding
`default_nettype none
`include "resistive_touch_event_mapper_macros.svh"

module rtem_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [rtem_pkg::OUT_TDATA_W-1:0] m_tdata,
    input wire logic [rtem_pkg::OUT_TUSER_W-1:0] m_tuser
);

    // the sequencer is busy right after taking a poll
    `RTEM_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // a conversion failure never carries a point
    `RTEM_ASSERT_IMP(a_error_no_point, aclk, aresetn, m_tvalid && m_tuser[0], !m_tdata[0])

    // without a point, state, coordinates and echoes are zero
    `RTEM_ASSERT_IMP(a_no_point_zero, aclk, aresetn, m_tvalid && !m_tdata[0], m_tdata[50:1] == '0)

    // a stalled result holds
    `RTEM_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind resistive_touch_event_mapper rtem_checker u_rtem_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);

`default_nettype wire
